// ----- sv/esc_pkg.sv -----
// esc_pkg: shared types, constants and table functions for the epoch seconds
// to calendar converter. Used by esc_ctrl, esc_datapath and the top level.
// Depends on nothing.
package esc_pkg;

  localparam int EpochYear   = 1904;
  localparam int SecsPerDay  = 86400;
  localparam int SecsPerHour = 3600;
  localparam int SecsPerMin  = 60;
  localparam int DaysPerYear = 365;
  localparam int DaysPer4Yr  = 4 * DaysPerYear + 1;
  localparam int CenturyLeap = 400;

  // Division by a constant: drop the power-of-two factor of the divisor, then
  // multiply by a rounded-up reciprocal of the odd part and keep the high bits.
  localparam int DayPreShift    = 7;         // 86400 = 2^7 * 675
  localparam int DayRecip       = 50903317;  // ceil(2^35 / 675)
  localparam int DayRecipShift  = 35;
  localparam int HourPreShift   = 4;         // 3600 = 2^4 * 225
  localparam int HourRecip      = 9321;      // ceil(2^21 / 225)
  localparam int HourRecipShift = 21;
  localparam int MinPreShift    = 2;         // 60 = 2^2 * 15
  localparam int MinRecip       = 1093;      // ceil(2^14 / 15)
  localparam int MinRecipShift  = 14;

  localparam logic [10:0] EpochYearVal = 11'(EpochYear);
  localparam logic [6:0]  EpochYoc     = 7'(EpochYear % 100);
  localparam logic [1:0]  EpochCentMod = 2'((EpochYear / 100) % (CenturyLeap / 100));

  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_DIV,
    DP_REM,
    DP_YEAR4,
    DP_YEAR1,
    DP_MONTH,
    DP_CAPTURE
  } dp_op_t;

  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_HOUR,
    DIV_MIN
  } div_sel_t;

  typedef struct packed {
    dp_op_t     op;
    div_sel_t   sel;
  } dp_cmd_t;

  typedef struct packed {
    logic blk_fit;
    logic yr_fit;
    logic mon_fit;
    logic last_month;
  } dp_stat_t;

  // Length of month m (1 = January) in days.
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- sv/esc_datapath.sv -----
// esc_datapath: reciprocal-multiply dividers, year/month walker and result
// register for the epoch seconds to calendar converter. Driven by esc_ctrl.
// Depends on esc_pkg.
module esc_datapath (
  input  logic             clk,
  input  logic [31:0]      in_epoch_seconds,
  input  esc_pkg::dp_cmd_t cmd,
  output esc_pkg::dp_stat_t stat,
  output logic [10:0]      out_cal_year,
  output logic [3:0]       out_cal_month,
  output logic [4:0]       out_cal_day,
  output logic [4:0]       out_cal_hour,
  output logic [5:0]       out_cal_minute,
  output logic [5:0]       out_cal_second
);
  import esc_pkg::*;

  logic [31:0] acc_r, acc_nxt;
  logic [15:0] days_r, days_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [10:0] year_r, year_nxt;
  logic [6:0]  yoc_r, yoc_nxt;     // year within century
  logic [1:0]  cmod_r, cmod_nxt;   // century mod 4
  logic [3:0]  month_r, month_nxt;

  logic [10:0] o_year_r;
  logic [3:0]  o_month_r;
  logic [4:0]  o_day_r;
  logic [4:0]  o_hour_r;
  logic [5:0]  o_minute_r;
  logic [5:0]  o_second_r;

  logic [50:0] day_prod;
  logic [26:0] hour_prod;
  logic [20:0] min_prod;
  logic        leap;
  logic [10:0] blk_len;
  logic [8:0]  yr_len;
  logic [4:0]  mon_len;

  // Quotient products; the hour step sees a time of day below 2^17 and the
  // minute step a remainder below 2^12.
  assign day_prod  = 51'(acc_r[31:DayPreShift]) * 51'(DayRecip);
  assign hour_prod = 27'(acc_r[16:HourPreShift]) * 27'(HourRecip);
  assign min_prod  = 21'(acc_r[11:MinPreShift]) * 21'(MinRecip);

  // Full leap rule: multiple of 4, and century years only when century % 4 == 0.
  assign leap    = (yoc_r[1:0] == 2'd0) && ((yoc_r != 7'd0) || (cmod_r == 2'd0));
  assign blk_len = leap ? 11'(DaysPer4Yr) : 11'(DaysPer4Yr - 1);
  assign yr_len  = leap ? 9'(DaysPerYear + 1) : 9'(DaysPerYear);
  assign mon_len = month_days(month_r, leap);

  assign stat.blk_fit    = (days_r >= 16'(blk_len));
  assign stat.yr_fit     = (days_r >= 16'(yr_len));
  assign stat.mon_fit    = (days_r >= 16'(mon_len));
  assign stat.last_month = (month_r == 4'd12);

  always_comb begin
    acc_nxt    = acc_r;
    days_nxt   = days_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    year_nxt   = year_r;
    yoc_nxt    = yoc_r;
    cmod_nxt   = cmod_r;
    month_nxt  = month_r;
    case (cmd.op)
      DP_LOAD: begin
        acc_nxt   = in_epoch_seconds;
        year_nxt  = EpochYearVal;
        yoc_nxt   = EpochYoc;
        cmod_nxt  = EpochCentMod;
        month_nxt = 4'd1;
      end
      DP_DIV: begin
        case (cmd.sel)
          DIV_DAY:  days_nxt   = day_prod[DayRecipShift +: 16];
          DIV_HOUR: hour_nxt   = hour_prod[HourRecipShift +: 5];
          DIV_MIN:  minute_nxt = min_prod[MinRecipShift +: 6];
          default:  minute_nxt = minute_r;
        endcase
      end
      DP_REM: begin
        case (cmd.sel)
          DIV_DAY:  acc_nxt = acc_r - 32'(days_r) * 32'(SecsPerDay);
          DIV_HOUR: acc_nxt = acc_r - 32'(hour_r) * 32'(SecsPerHour);
          DIV_MIN:  acc_nxt = acc_r - 32'(minute_r) * 32'(SecsPerMin);
          default:  acc_nxt = acc_r;
        endcase
      end
      DP_YEAR4: begin
        if (stat.blk_fit) begin
          days_nxt = days_r - 16'(blk_len);
          year_nxt = year_r + 11'd4;
          if (yoc_r >= 7'd96) begin
            yoc_nxt  = yoc_r - 7'd96;
            cmod_nxt = cmod_r + 2'd1;
          end else begin
            yoc_nxt = yoc_r + 7'd4;
          end
        end
      end
      DP_YEAR1: begin
        if (stat.yr_fit) begin
          days_nxt = days_r - 16'(yr_len);
          year_nxt = year_r + 11'd1;
          if (yoc_r == 7'd99) begin
            yoc_nxt  = 7'd0;
            cmod_nxt = cmod_r + 2'd1;
          end else begin
            yoc_nxt = yoc_r + 7'd1;
          end
        end
      end
      DP_MONTH: begin
        if (stat.mon_fit && !stat.last_month) begin
          days_nxt  = days_r - 16'(mon_len);
          month_nxt = month_r + 4'd1;
        end
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    days_r   <= days_nxt;
    hour_r   <= hour_nxt;
    minute_r <= minute_nxt;
    year_r   <= year_nxt;
    yoc_r    <= yoc_nxt;
    cmod_r   <= cmod_nxt;
    month_r  <= month_nxt;
    if (cmd.op == DP_CAPTURE) begin
      o_year_r   <= year_r;
      o_month_r  <= month_r;
      o_day_r    <= days_r[4:0] + 5'd1;
      o_hour_r   <= hour_r;
      o_minute_r <= minute_r;
      o_second_r <= acc_r[5:0];
    end
  end

  assign out_cal_year   = o_year_r;
  assign out_cal_month  = o_month_r;
  assign out_cal_day    = o_day_r;
  assign out_cal_hour   = o_hour_r;
  assign out_cal_minute = o_minute_r;
  assign out_cal_second = o_second_r;

endmodule

// ----- sv/esc_ctrl.sv -----
// esc_ctrl: sequencer for the epoch seconds to calendar converter. Steps the
// datapath through division, year, month and capture phases; owns the handshakes.
// Depends on esc_pkg.
module esc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  esc_pkg::dp_stat_t stat,
  output esc_pkg::dp_cmd_t  cmd
);
  import esc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_DAY,
    S_REM_DAY,
    S_DIV_HOUR,
    S_REM_HOUR,
    S_DIV_MIN,
    S_REM_MIN,
    S_YEAR4,
    S_YEAR1,
    S_MONTH,
    S_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = rst_n && (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = DP_NOP;
    cmd.sel       = DIV_DAY;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = DP_LOAD;
          state_nxt = S_DIV_DAY;
        end
      end
      S_DIV_DAY: begin
        cmd.op    = DP_DIV;
        cmd.sel   = DIV_DAY;
        state_nxt = S_REM_DAY;
      end
      S_REM_DAY: begin
        cmd.op    = DP_REM;
        cmd.sel   = DIV_DAY;
        state_nxt = S_DIV_HOUR;
      end
      S_DIV_HOUR: begin
        cmd.op    = DP_DIV;
        cmd.sel   = DIV_HOUR;
        state_nxt = S_REM_HOUR;
      end
      S_REM_HOUR: begin
        cmd.op    = DP_REM;
        cmd.sel   = DIV_HOUR;
        state_nxt = S_DIV_MIN;
      end
      S_DIV_MIN: begin
        cmd.op    = DP_DIV;
        cmd.sel   = DIV_MIN;
        state_nxt = S_REM_MIN;
      end
      S_REM_MIN: begin
        cmd.op    = DP_REM;
        cmd.sel   = DIV_MIN;
        state_nxt = S_YEAR4;
      end
      S_YEAR4: begin
        cmd.op = DP_YEAR4;
        if (!stat.blk_fit) state_nxt = S_YEAR1;
      end
      S_YEAR1: begin
        cmd.op = DP_YEAR1;
        if (!stat.yr_fit) state_nxt = S_MONTH;
      end
      S_MONTH: begin
        cmd.op = DP_MONTH;
        if (!stat.mon_fit || stat.last_month) state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.op        = DP_CAPTURE;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DIV_DAY))
    else $error("accepted transaction did not start the day division");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("input ready while a transaction is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before it was taken");

  a_capture_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (!out_valid_r || out_ready)) |=> (out_valid_r && state_r == S_IDLE))
    else $error("capture did not present a result");

endmodule

// ----- sv/epoch_seconds_to_calendar.sv -----
// epoch_seconds_to_calendar: top level. Converts seconds since 1904-01-01
// 00:00:00 into Gregorian date and time of day. Depends on esc_pkg, esc_ctrl
// and esc_datapath.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_ready, in_epoch_seconds    | into block
//   out     | out_valid, out_ready, out_cal_*         | out of block
//
// Sequencing: one transaction at a time; the next accept comes in the cycle after
//   the capture at the earliest. The sequencer runs three divisions by constants
//   (quotient by reciprocal multiply, then remainder, each in its own state), then
//   walks 4-year blocks (up to 34), up to 3 single years and up to 11 months,
//   each walk ending in an exit step, and ends with one capture.
// Reset: synchronous, active low; clears the sequencer and output valid only.
// Stalls: the result register holds while out_ready is low; a new transaction is
//   accepted meanwhile, and only its capture waits for the register to drain.
module epoch_seconds_to_calendar (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] out_cal_year,
  output logic [3:0]  out_cal_month,
  output logic [4:0]  out_cal_day,
  output logic [4:0]  out_cal_hour,
  output logic [5:0]  out_cal_minute,
  output logic [5:0]  out_cal_second
);
  import esc_pkg::*;

  // Command and status between sequencer and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer: owns both handshakes and walks the phases
  esc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: divider, calendar walker and result register
  esc_datapath u_datapath (
    .clk              (clk),
    .in_epoch_seconds (in_epoch_seconds),
    .cmd              (cmd),
    .stat             (stat),
    .out_cal_year     (out_cal_year),
    .out_cal_month    (out_cal_month),
    .out_cal_day      (out_cal_day),
    .out_cal_hour     (out_cal_hour),
    .out_cal_minute   (out_cal_minute),
    .out_cal_second   (out_cal_second)
  );

endmodule

// ----- tb/epoch_seconds_to_calendar_test.sv -----
// epoch_seconds_to_calendar_test: self-checking testbench for the seconds to
// calendar converter. It holds its own calendar predictor and a result scoreboard.
// Depends on esc_pkg and on the epoch_seconds_to_calendar top level.
module epoch_seconds_to_calendar_test;
  timeunit 1ns;
  timeprecision 1ps;

  import esc_pkg::*;

  localparam int          HalfPeriod    = 5;
  localparam int          ResetCycles   = 3;
  localparam int          RandomItems   = 1250;
  localparam int          DrainCycles   = 120;      // above the worst accept-to-result latency
  localparam int unsigned CycleLimit    = 1_000_000;  // several times the slowest legal run
  localparam int unsigned LongStallAt   = 400;      // results checked before the long hold-off
  localparam int unsigned LongStallLen  = 600;
  localparam logic [31:0] MaxSeconds    = 32'hFFFF_FFFF;

  // One calendar result, plus the input that caused it for error messages.
  typedef struct {
    logic [31:0] secs;
    logic [10:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_stamp_t;

  // Scoreboard: predicts the calendar stamp of each accepted timestamp and
  // checks results in order against the oldest pending prediction.
  class calendar_scoreboard;
    cal_stamp_t  pending_q[$];
    int unsigned checked;
    int unsigned errors;
    int unsigned leap_days_seen;
    int unsigned earliest_year = 9999;
    int unsigned latest_year;

    static function bit is_leap_year(int unsigned yr);
      return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % CenturyLeap == 0);
    endfunction

    static function int unsigned days_in_year(int unsigned yr);
      return is_leap_year(yr) ? DaysPerYear + 1 : DaysPerYear;
    endfunction

    static function int unsigned days_in_month(int unsigned mon, bit leap);
      case (mon)
        2:             return leap ? 29 : 28;
        4, 6, 9, 11:   return 30;
        default:       return 31;
      endcase
    endfunction

    // Split off the time of day, then walk whole years and months.
    function cal_stamp_t predict_stamp(logic [31:0] secs);
      cal_stamp_t  s;
      int unsigned tod;
      int unsigned days_left;
      int unsigned yr;
      int unsigned mon;
      bit          leap;
      tod       = secs % SecsPerDay;
      days_left = secs / SecsPerDay;
      yr        = EpochYear;
      while (days_left >= days_in_year(yr)) begin
        days_left -= days_in_year(yr);
        yr++;
      end
      leap = is_leap_year(yr);
      mon  = 1;
      while (mon < 12 && days_left >= days_in_month(mon, leap)) begin
        days_left -= days_in_month(mon, leap);
        mon++;
      end
      s.secs   = secs;
      s.year   = 11'(yr);
      s.month  = 4'(mon);
      s.day    = 5'(days_left + 1);
      s.hour   = 5'(tod / SecsPerHour);
      s.minute = 6'((tod % SecsPerHour) / SecsPerMin);
      s.second = 6'(tod % SecsPerMin);
      return s;
    endfunction

    function void note_timestamp(logic [31:0] secs);
      pending_q.push_back(predict_stamp(secs));
    endfunction

    function void check_stamp(cal_stamp_t got);
      cal_stamp_t exp_s;
      if (pending_q.size() == 0) begin
        $error("unexpected result %0d-%0d-%0d %0d:%0d:%0d with nothing pending",
               got.year, got.month, got.day, got.hour, got.minute, got.second);
        errors++;
        return;
      end
      exp_s = pending_q.pop_front();
      checked++;
      if (got.year !== exp_s.year) begin
        $error("cal_year (secs %0d): expected %0d, actual %0d", exp_s.secs, exp_s.year, got.year);
        errors++;
      end
      if (got.month !== exp_s.month) begin
        $error("cal_month (secs %0d): expected %0d, actual %0d",
               exp_s.secs, exp_s.month, got.month);
        errors++;
      end
      if (got.day !== exp_s.day) begin
        $error("cal_day (secs %0d): expected %0d, actual %0d", exp_s.secs, exp_s.day, got.day);
        errors++;
      end
      if (got.hour !== exp_s.hour) begin
        $error("cal_hour (secs %0d): expected %0d, actual %0d", exp_s.secs, exp_s.hour, got.hour);
        errors++;
      end
      if (got.minute !== exp_s.minute) begin
        $error("cal_minute (secs %0d): expected %0d, actual %0d",
               exp_s.secs, exp_s.minute, got.minute);
        errors++;
      end
      if (got.second !== exp_s.second) begin
        $error("cal_second (secs %0d): expected %0d, actual %0d",
               exp_s.secs, exp_s.second, got.second);
        errors++;
      end
      if (exp_s.month == 2 && exp_s.day == 29) leap_days_seen++;
      if (exp_s.year < earliest_year) earliest_year = exp_s.year;
      if (exp_s.year > latest_year) latest_year = exp_s.year;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_epoch_seconds = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [10:0] out_cal_year;
  logic [3:0]  out_cal_month;
  logic [4:0]  out_cal_day;
  logic [4:0]  out_cal_hour;
  logic [5:0]  out_cal_minute;
  logic [5:0]  out_cal_second;

  calendar_scoreboard sb;

  // Sender burst state: items left in the current burst.
  int unsigned burst_left;
  int unsigned directed_sent;
  int unsigned random_sent;
  int unsigned cycle_count;

  epoch_seconds_to_calendar i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_epoch_seconds(in_epoch_seconds),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cal_year    (out_cal_year),
    .out_cal_month   (out_cal_month),
    .out_cal_day     (out_cal_day),
    .out_cal_hour    (out_cal_hour),
    .out_cal_minute  (out_cal_minute),
    .out_cal_second  (out_cal_second)
  );

  always #HalfPeriod clk = ~clk;

  // Seconds count of a calendar instant plus a signed offset, clamped to
  // the 32-bit range so boundary probes near the ends stay legal.
  function automatic logic [31:0] seconds_at(int unsigned yr, int unsigned mon,
                                             int unsigned dom, int unsigned hh,
                                             int unsigned mm, int unsigned ss, int offset);
    longint total;
    bit     leap;
    total = 0;
    for (int unsigned y = EpochYear; y < yr; y++)
      total += calendar_scoreboard::days_in_year(y);
    leap = calendar_scoreboard::is_leap_year(yr);
    for (int unsigned m = 1; m < mon; m++)
      total += calendar_scoreboard::days_in_month(m, leap);
    total = (total + longint'(dom) - 1) * SecsPerDay + longint'(hh) * SecsPerHour
            + longint'(mm) * SecsPerMin + longint'(ss) + longint'(offset);
    if (total < 0) return '0;
    if (total > longint'(MaxSeconds)) return MaxSeconds;
    return 32'(total);
  endfunction

  // Drop valid and idle the input; scramble the idle payload so it is never relied on.
  task automatic idle_input(int unsigned n);
    if (n == 0) return;
    in_valid         <= 1'b0;
    in_epoch_seconds <= $urandom;
    repeat (n) @(posedge clk);
  endtask

  // Present one timestamp and hold it until the block takes the transaction.
  task automatic send_timestamp(logic [31:0] secs);
    if (burst_left == 0) begin
      // Mostly short bursts with gaps; now and then a long back-to-back run.
      if ($urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(20, 60);
      end else begin
        burst_left = $urandom_range(1, 10);
        idle_input($urandom_range(0, 60));
      end
    end
    burst_left--;
    in_valid         <= 1'b1;
    in_epoch_seconds <= secs;
    do @(posedge clk); while (!in_ready);
    sb.note_timestamp(secs);
  endtask

  // Timestamps: fully random, any instant, near a range end, or near the end of a year or a month's first or last day.
  function automatic logic [31:0] random_timestamp();
    int unsigned yr;
    int unsigned mon;
    int unsigned dom;
    int unsigned last_dom;
    yr       = $urandom_range(EpochYear, 2039);
    mon      = $urandom_range(1, 12);
    last_dom = calendar_scoreboard::days_in_month(mon, calendar_scoreboard::is_leap_year(yr));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5: begin
        // Straddle the end of the month's last day or of its first day, within two seconds.
        dom = ($urandom_range(0, 1) == 1) ? last_dom : 1;
        return seconds_at(yr, mon, dom, 23, 59, 59, $urandom_range(0, 4) - 2);
      end
      6: begin
        // Straddle a year end.
        return seconds_at(yr, 12, 31, 23, 59, 59, $urandom_range(0, 6) - 3);
      end
      7: begin
        dom = $urandom_range(1, last_dom);
        return seconds_at(yr, mon, dom, $urandom_range(0, 23), $urandom_range(0, 59),
                          $urandom_range(0, 59), 0);
      end
      8: return $urandom_range(0, 200_000);
      default: return MaxSeconds - $urandom_range(0, 5_000_000);
    endcase
  endfunction

  // Stimulus: reset, directed corners, then random timestamps, then drain.
  initial begin : stimulus
    logic [31:0] corners[$];
    sb = new();
    burst_left = 0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    // Field extremes, time-of-day rollovers, the 1904 and 2000 leap days,
    // a non-leap February, year ends and the top of the input range.
    corners = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
                seconds_at(1904, 2, 28, 23, 59, 59, 0), seconds_at(1904, 2, 29, 0, 0, 0, 0),
                seconds_at(1904, 2, 29, 23, 59, 59, 0), seconds_at(1904, 12, 31, 23, 59, 59, 0),
                seconds_at(1905, 1, 1, 0, 0, 0, 0), seconds_at(1905, 2, 28, 23, 59, 59, 0),
                seconds_at(1905, 3, 1, 0, 0, 0, 0), seconds_at(1999, 12, 31, 23, 59, 59, 0),
                seconds_at(2000, 2, 29, 12, 34, 56, 0), seconds_at(2000, 3, 1, 0, 0, 0, 0),
                seconds_at(2000, 12, 31, 23, 59, 59, 0), seconds_at(2001, 1, 1, 0, 0, 0, 0),
                seconds_at(2039, 12, 31, 23, 59, 59, 0), seconds_at(2040, 1, 1, 0, 0, 0, 0),
                32'h7FFF_FFFF, 32'h8000_0000, MaxSeconds};
    foreach (corners[k]) begin
      send_timestamp(corners[k]);
      directed_sent++;
    end

    for (int n = 0; n < RandomItems; n++) begin
      send_timestamp(random_timestamp());
      random_sent++;
    end
    idle_input(1);

    // Wait for every prediction to be matched, then watch for strays.
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Converted %0d directed and %0d random timestamps; %0d results checked.",
             directed_sent, random_sent, sb.checked);
    $display("Years %0d to %0d covered, %0d results on a leap day.",
             sb.earliest_year, sb.latest_year, sb.leap_days_seen);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Receiver: advance through ready patterns of its own, and once hold off
  // for a long stretch so the block fills and backs up the input side.
  initial begin : receiver
    int unsigned rx_cycle;
    int unsigned hold_left;
    bit          long_stall_done;
    bit          rdy;
    rx_cycle        = 0;
    hold_left       = 0;
    long_stall_done = 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (!long_stall_done && sb.checked >= LongStallAt) begin
        long_stall_done = 1'b1;
        hold_left       = LongStallLen;
      end
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case ((rx_cycle / 250) % 4)
          0:       rdy = 1'b1;
          1:       rdy = ($urandom_range(0, 9) < 7);
          2:       rdy = ($urandom_range(0, 9) < 3);
          default: rdy = ((rx_cycle % 7) >= 3);
        endcase
      end
      out_ready <= rdy;
    end
  end

  // Result monitor: check every transaction on the output channel.
  always @(posedge clk) begin : result_monitor
    cal_stamp_t got;
    if (rst_n && out_valid && out_ready) begin
      got.secs   = '0;
      got.year   = out_cal_year;
      got.month  = out_cal_month;
      got.day    = out_cal_day;
      got.hour   = out_cal_hour;
      got.minute = out_cal_minute;
      got.second = out_cal_second;
      sb.check_stamp(got);
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results still pending.",
               cycle_count, sb.pending_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule

// ----- epoch_seconds_to_calendar.f -----
sv/esc_pkg.sv
sv/esc_datapath.sv
sv/esc_ctrl.sv
sv/epoch_seconds_to_calendar.sv
tb/epoch_seconds_to_calendar_test.sv
